@@ src/assert_macros.svh @@
// assertion macros shared by the rtl, clocked on i_clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition must never hold
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition seen");
// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle condition failed");
`else
`define ASSERT_NEVER(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/rvx_pkg.sv @@
package rvx_pkg;

    // data store size in bytes, a power of two
    localparam int unsigned DATA_BYTES    = 4096;
    localparam int unsigned WORD_BYTES    = 4;
    localparam int          DMEM_ABITS    = $clog2(DATA_BYTES);
    localparam int          DMEM_ROWS     = DATA_BYTES / WORD_BYTES;
    localparam int          DMEM_ROW_BITS = DMEM_ABITS - $clog2(WORD_BYTES);
    localparam int          RF_DEPTH      = 32;

    // major opcodes
    localparam logic [6:0] OPC_REG    = 7'b0110011;
    localparam logic [6:0] OPC_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;

    // alu funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // load and store funct3
    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_SB  = 3'd0;
    localparam logic [2:0] F3_SH  = 3'd1;
    localparam logic [2:0] F3_SW  = 3'd2;
    localparam logic [2:0] F3_JALR = 3'd0;

    // access size, low bits of funct3
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    typedef struct packed {
        logic [6:0]         opcode;
        logic [2:0]         funct3;
        logic               alt_bit;
        logic [4:0]         dest_index;
        logic [4:0]         src1_index;
        logic [4:0]         src2_index;
        logic signed [31:0] immediate;
    } t_instr;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  written_reg;
        logic [31:0] written_value;
        logic        store_done;
        logic [31:0] store_address;
        logic        illegal;
    } t_result;

    typedef struct packed {
        logic        en;
        logic [4:0]  rd;
        logic [31:0] val;
    } t_rf_wr;

    typedef struct packed {
        logic                  store;
        logic [DMEM_ABITS-1:0] addr;
        logic [1:0]            size;
        logic [31:0]           wdata;
    } t_dmem_req;

    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [31:0] val;
        logic        is_load;
        logic        store;
        logic [31:0] addr;
        logic        ill;
    } t_exec_out;

endpackage

@@ src/rvx_ram.sv @@
module rvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/rvx_regfile.sv @@
`include "assert_macros.svh"

module rvx_regfile (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [4:0]      i_ra1,
    input  logic [4:0]      i_ra2,
    input  rvx_pkg::t_rf_wr i_wr,
    input  rvx_pkg::t_rf_wr i_pend,
    output logic [31:0]     o_rs1_val,
    output logic [31:0]     o_rs2_val
);

    logic [4:0]                     r_ra [2];
    logic [4:0]                     ra_in [2];
    logic [31:0]                    ram_q [2];
    logic [31:0]                    rs_val [2];
    logic [rvx_pkg::RF_DEPTH-1:0]   r_valid;
    rvx_pkg::t_rf_wr                r_last;

    assign ra_in[0] = i_ra1;
    assign ra_in[1] = i_ra2;

    // two copies so both sources read in the same cycle
    for (genvar g = 0; g < 2; g++) begin : g_copy
        rvx_ram #(
            .WIDTH (32),
            .DEPTH (rvx_pkg::RF_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_wr.en),
            .i_waddr (i_wr.rd),
            .i_wdata (i_wr.val),
            .i_raddr (ra_in[g]),
            .o_rdata (ram_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_ra[0] <= i_ra1;
        r_ra[1] <= i_ra2;
    end

    // last write covers the read that raced it at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_last  <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.rd] <= 1'b1;
            r_last           <= i_wr;
        end
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (r_ra[k] == '0) begin
                rs_val[k] = '0;
            end else if (i_pend.en && i_pend.rd == r_ra[k]) begin
                rs_val[k] = i_pend.val;
            end else if (r_last.en && r_last.rd == r_ra[k]) begin
                rs_val[k] = r_last.val;
            end else if (r_valid[r_ra[k]]) begin
                rs_val[k] = ram_q[k];
            end else begin
                rs_val[k] = '0;
            end
        end
    end

    assign o_rs1_val = rs_val[0];
    assign o_rs2_val = rs_val[1];

    `ASSERT_NEVER(a_x0_never_valid, r_valid[0])

endmodule

@@ src/rvx_dmem.sv @@
`include "assert_macros.svh"

module rvx_dmem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  rvx_pkg::t_dmem_req i_req,
    output logic               o_busy,
    output logic [31:0]        o_rdata
);

    localparam int RB = rvx_pkg::DMEM_ROW_BITS;
    localparam int NL = rvx_pkg::WORD_BYTES;

    logic          r_clearing;
    logic [RB-1:0] r_clr_row;
    logic [1:0]    r_off;
    logic [RB-1:0] r_row [NL];

    logic [1:0]    off;
    logic [RB-1:0] row0;
    logic [1:0]    bsel [NL];
    logic          active [NL];
    logic [RB-1:0] lane_row [NL];
    logic          ram_we [NL];
    logic [RB-1:0] ram_waddr [NL];
    logic [7:0]    ram_wdata [NL];
    logic [RB-1:0] ram_raddr [NL];
    logic [7:0]    ram_q [NL];

    // byte lane l holds addresses with low bits l; a wrapped access
    // takes the next row in the lanes below the start offset
    always_comb begin
        off  = i_req.addr[1:0];
        row0 = i_req.addr[rvx_pkg::DMEM_ABITS-1:2];
        for (int l = 0; l < NL; l++) begin
            bsel[l]      = 2'(l) - off;
            lane_row[l]  = row0 + RB'(2'(l) < off);
            active[l]    = (i_req.size == rvx_pkg::SZ_WORD)
                        || (i_req.size == rvx_pkg::SZ_HALF && !bsel[l][1])
                        || (bsel[l] == 2'd0);
            ram_we[l]    = r_clearing || (i_go && i_req.store && active[l]);
            ram_waddr[l] = r_clearing ? r_clr_row : lane_row[l];
            ram_wdata[l] = r_clearing ? 8'h00 : i_req.wdata[{bsel[l], 3'b000} +: 8];
            // hold the read rows while the load waits downstream
            ram_raddr[l] = i_go ? lane_row[l] : r_row[l];
            o_rdata[8*l +: 8] = ram_q[2'(l) + r_off];
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        rvx_ram #(
            .WIDTH (8),
            .DEPTH (rvx_pkg::DMEM_ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_waddr (ram_waddr[g]),
            .i_wdata (ram_wdata[g]),
            .i_raddr (ram_raddr[g]),
            .o_rdata (ram_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_off <= off;
            for (int l = 0; l < NL; l++) begin
                r_row[l] <= lane_row[l];
            end
        end
    end

    // zeroing sweep, one row of every lane per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_busy = r_clearing;

    `ASSERT_NEXT(a_clear_once, !r_clearing, !r_clearing)
    `ASSERT_NEVER(a_go_while_clear, r_clearing && i_go)

endmodule

@@ src/rvx_exec.sv @@
module rvx_exec (
    input  rvx_pkg::t_instr    i_instr,
    input  logic [31:0]        i_pc,
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    output rvx_pkg::t_exec_out o_ex
);

    logic [31:0] imm;
    logic [31:0] pc4;
    logic [31:0] pc_imm;
    logic [31:0] addr;
    logic [31:0] op_b;
    logic        alt;
    logic [4:0]  shamt;
    logic [31:0] alu_res;
    logic        take;
    logic [2:0]  f3;

    assign imm    = $unsigned(i_instr.immediate);
    assign f3     = i_instr.funct3;
    assign pc4    = i_pc + 32'd4;
    assign pc_imm = i_pc + imm;
    assign addr   = i_a + imm;

    always_comb begin
        op_b  = (i_instr.opcode == rvx_pkg::OPC_IMM) ? imm : i_b;
        if (i_instr.opcode == rvx_pkg::OPC_REG) begin
            alt = (f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR) && i_instr.alt_bit;
        end else begin
            alt = (f3 == rvx_pkg::F3_SR) && imm[10];
        end
        shamt = op_b[4:0];
        case (f3)
            rvx_pkg::F3_ADD:  alu_res = alt ? i_a - op_b : i_a + op_b;
            rvx_pkg::F3_SLL:  alu_res = i_a << shamt;
            rvx_pkg::F3_SLT:  alu_res = {31'd0, $signed(i_a) < $signed(op_b)};
            rvx_pkg::F3_SLTU: alu_res = {31'd0, i_a < op_b};
            rvx_pkg::F3_XOR:  alu_res = i_a ^ op_b;
            rvx_pkg::F3_SR:   alu_res = alt ? $unsigned($signed(i_a) >>> shamt)
                                            : i_a >> shamt;
            rvx_pkg::F3_OR:   alu_res = i_a | op_b;
            default:          alu_res = i_a & op_b;
        endcase
    end

    always_comb begin
        o_ex      = '0;
        o_ex.npc  = pc4;
        o_ex.addr = addr;
        take      = 1'b0;
        unique case (i_instr.opcode) inside
            rvx_pkg::OPC_REG, rvx_pkg::OPC_IMM: begin
                o_ex.wr  = 1'b1;
                o_ex.val = alu_res;
            end
            rvx_pkg::OPC_LOAD: begin
                unique case (f3) inside
                    rvx_pkg::F3_LB, rvx_pkg::F3_LH, rvx_pkg::F3_LW,
                    rvx_pkg::F3_LBU, rvx_pkg::F3_LHU: begin
                        o_ex.wr      = 1'b1;
                        o_ex.is_load = 1'b1;
                    end
                    default: o_ex.ill = 1'b1;
                endcase
            end
            rvx_pkg::OPC_STORE: begin
                unique case (f3) inside
                    rvx_pkg::F3_SB, rvx_pkg::F3_SH, rvx_pkg::F3_SW: o_ex.store = 1'b1;
                    default: o_ex.ill = 1'b1;
                endcase
            end
            rvx_pkg::OPC_BRANCH: begin
                unique case (f3)
                    rvx_pkg::F3_BEQ:  take = i_a == i_b;
                    rvx_pkg::F3_BNE:  take = i_a != i_b;
                    rvx_pkg::F3_BLT:  take = $signed(i_a) < $signed(i_b);
                    rvx_pkg::F3_BGE:  take = !($signed(i_a) < $signed(i_b));
                    rvx_pkg::F3_BLTU: take = i_a < i_b;
                    rvx_pkg::F3_BGEU: take = i_a >= i_b;
                    default:          o_ex.ill = 1'b1;
                endcase
                if (take) begin
                    o_ex.npc = pc_imm;
                end
            end
            rvx_pkg::OPC_JAL: begin
                o_ex.wr  = 1'b1;
                o_ex.val = pc4;
                o_ex.npc = pc_imm;
            end
            rvx_pkg::OPC_JALR: begin
                if (f3 == rvx_pkg::F3_JALR) begin
                    o_ex.wr  = 1'b1;
                    o_ex.val = pc4;
                    o_ex.npc = {addr[31:1], 1'b0};
                end else begin
                    o_ex.ill = 1'b1;
                end
            end
            rvx_pkg::OPC_LUI: begin
                o_ex.wr  = 1'b1;
                o_ex.val = imm;
            end
            rvx_pkg::OPC_AUIPC: begin
                o_ex.wr  = 1'b1;
                o_ex.val = pc_imm;
            end
            default: o_ex.ill = 1'b1;
        endcase
        // writes to x0 vanish
        if (i_instr.dest_index == '0) begin
            o_ex.wr      = 1'b0;
            o_ex.val     = '0;
            o_ex.is_load = 1'b0;
        end
    end

endmodule

@@ src/rv32i_execute_unit.sv @@
// RV32I execute unit: one decoded instruction in, one result out.
// Input channel i_valid / o_stall carries i_instr; output channel
// o_valid / i_stall carries o_result. Each side transfers at a rising
// edge with valid high and stall low.
// Two stages: execute (register file read data, ALU, branch, PC update,
// store write, load read issue) and result (load data alignment, register
// write-back at transfer). The result register loads as execute advances.
// Throughput is one instruction per cycle unless the receiver stalls or
// a load hazard holds: an instruction that reads the destination of the
// load just ahead of it waits until that load leaves the result stage, as
// load data only appear after the registered read of the data store lanes.
// After reset the data store is swept to zero, four bytes per cycle, with
// o_stall high until the sweep ends. The register file reads zero until
// written and the PC starts at start_pc, which reset sets to 0.
// i_cfg_wr_en writes start_pc in any cycle outside reset. When the receiver
// stalls, the result holds, and an item in execute holds and raises o_stall.
`include "assert_macros.svh"

module rv32i_execute_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rvx_pkg::t_instr  i_instr,
    output logic             o_valid,
    input  logic             i_stall,
    output rvx_pkg::t_result o_result,
    input  logic             i_cfg_wr_en,
    input  logic [31:0]      i_cfg_wr_data
);

    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        is_load;
        logic [2:0]  ld_f3;
        logic        store;
        logic [31:0] saddr;
        logic        ill;
    } t_s2_item;

    logic               r_s1_valid;
    rvx_pkg::t_instr    r_s1;
    logic               r_s2_valid;
    t_s2_item           r_s2;
    t_s2_item           n_s2;
    logic [31:0]        r_pc;
    logic [31:0]        r_start_pc;
    logic [31:0]        n_start_pc;

    logic               in_xfer;
    logic               out_xfer;
    logic               s2_free;
    logic               load_hazard;
    logic               s1_adv;
    logic               dmem_busy;
    logic [31:0]        dmem_rdata;
    logic [31:0]        ld_val;
    logic [31:0]        rs1_val;
    logic [31:0]        rs2_val;
    logic [4:0]         rf_ra1;
    logic [4:0]         rf_ra2;
    rvx_pkg::t_rf_wr    rf_wr;
    rvx_pkg::t_rf_wr    rf_pend;
    rvx_pkg::t_dmem_req dmem_req;
    rvx_pkg::t_exec_out ex;

    // pipeline control
    assign s2_free     = !r_s2_valid || !i_stall;
    assign load_hazard = r_s2_valid && r_s2.is_load
                      && (r_s2.rd == r_s1.src1_index || r_s2.rd == r_s1.src2_index);
    assign s1_adv      = r_s1_valid && s2_free && !load_hazard;
    assign o_stall     = dmem_busy || (r_s1_valid && !s1_adv);
    assign in_xfer     = i_valid && !o_stall;
    assign out_xfer    = r_s2_valid && !i_stall;
    assign o_valid     = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (out_xfer) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1 <= i_instr;
        end
        if (s1_adv) begin
            r_s2 <= n_s2;
        end
    end

    // pc follows start_pc as reset leaves it
    always_comb begin
        if (!i_rst_n) begin
            n_start_pc = '0;
        end else if (i_cfg_wr_en) begin
            n_start_pc = i_cfg_wr_data;
        end else begin
            n_start_pc = r_start_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start_pc <= n_start_pc;
        if (!i_rst_n) begin
            r_pc <= n_start_pc;
        end else if (s1_adv) begin
            r_pc <= ex.npc;
        end
    end

    // register file: reread the held sources while the execute stage waits
    assign rf_ra1 = in_xfer ? i_instr.src1_index : r_s1.src1_index;
    assign rf_ra2 = in_xfer ? i_instr.src2_index : r_s1.src2_index;

    always_comb begin
        rf_pend.en  = r_s2_valid && r_s2.wr && !r_s2.is_load;
        rf_pend.rd  = r_s2.rd;
        rf_pend.val = r_s2.val;
        rf_wr.en    = out_xfer && r_s2.wr;
        rf_wr.rd    = r_s2.rd;
        rf_wr.val   = o_result.written_value;
    end

    rvx_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ra1     (rf_ra1),
        .i_ra2     (rf_ra2),
        .i_wr      (rf_wr),
        .i_pend    (rf_pend),
        .o_rs1_val (rs1_val),
        .o_rs2_val (rs2_val)
    );

    rvx_exec u_exec (
        .i_instr (r_s1),
        .i_pc    (r_pc),
        .i_a     (rs1_val),
        .i_b     (rs2_val),
        .o_ex    (ex)
    );

    always_comb begin
        dmem_req.store = ex.store;
        dmem_req.addr  = ex.addr[rvx_pkg::DMEM_ABITS-1:0];
        dmem_req.size  = r_s1.funct3[1:0];
        dmem_req.wdata = rs2_val;
    end

    rvx_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (s1_adv),
        .i_req   (dmem_req),
        .o_busy  (dmem_busy),
        .o_rdata (dmem_rdata)
    );

    always_comb begin
        n_s2.npc     = ex.npc;
        n_s2.wr      = ex.wr;
        n_s2.rd      = ex.wr ? r_s1.dest_index : 5'd0;
        n_s2.val     = ex.val;
        n_s2.is_load = ex.is_load;
        n_s2.ld_f3   = r_s1.funct3;
        n_s2.store   = ex.store;
        n_s2.saddr   = ex.store ? ex.addr : 32'd0;
        n_s2.ill     = ex.ill;
    end

    // load data extension
    always_comb begin
        unique case (r_s2.ld_f3)
            rvx_pkg::F3_LB:  ld_val = {{24{dmem_rdata[7]}}, dmem_rdata[7:0]};
            rvx_pkg::F3_LH:  ld_val = {{16{dmem_rdata[15]}}, dmem_rdata[15:0]};
            rvx_pkg::F3_LBU: ld_val = {24'd0, dmem_rdata[7:0]};
            rvx_pkg::F3_LHU: ld_val = {16'd0, dmem_rdata[15:0]};
            default:         ld_val = dmem_rdata;
        endcase
    end

    always_comb begin
        o_result.next_pc       = r_s2.npc;
        o_result.reg_written   = r_s2.wr;
        o_result.written_reg   = r_s2.rd;
        o_result.written_value = r_s2.is_load ? ld_val : r_s2.val;
        o_result.store_done    = r_s2.store;
        o_result.store_address = r_s2.saddr;
        o_result.illegal       = r_s2.ill;
    end

    `ASSERT_NEXT(a_pc_hold, !s1_adv, r_pc == $past(r_pc))
    `ASSERT_NEVER(a_no_x0_write, r_s2_valid && r_s2.wr && r_s2.rd == 5'd0)
    `ASSERT_NEVER(a_idle_in_clear, dmem_busy && (r_s1_valid || r_s2_valid))

endmodule
